/* src/ialt_pkg.sv */
// Package: types, character codes and class functions of the tokenizer.
`default_nettype none
package ialt_pkg;

  localparam int unsigned INDENT_BITS = 16;
  localparam int unsigned TAB_BITS    = 4;
  localparam int unsigned NUM_EV      = 3;

  localparam logic [TAB_BITS-1:0] TAB_RESET = 4'd2;
  localparam logic [INDENT_BITS-1:0] INDENT_MAX = {INDENT_BITS{1'b1}};

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  typedef enum logic [2:0] {
    MODE_LINE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_GAP     = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_STR     = 3'd4,
    MODE_STR_ESC = 3'd5,
    MODE_COMMA   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    EV_INDENT = 2'd0,
    EV_BYTE   = 2'd1,
    EV_END    = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] tok_byte;
    logic       first;
    logic       unterm;
  } ev_t;

  typedef ev_t [NUM_EV-1:0] ev_list_t;

  function automatic logic is_space_f(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_single_f(logic [7:0] c);
    return c == CH_LPAR || c == CH_RPAR || c == CH_APOS || c == CH_BTICK || c == CH_AT;
  endfunction

  function automatic logic is_word_f(logic [7:0] c);
    return !is_space_f(c) && !is_single_f(c) && c != CH_HASH && c != CH_DQUOTE &&
           c != CH_COMMA;
  endfunction

endpackage
`default_nettype wire

/* src/ialt_step.sv */
// Step logic: events and next scan state for one source byte.
`default_nettype none
module ialt_step
  import ialt_pkg::*;
(
  input  mode_e                  mode_i,
  input  logic [INDENT_BITS-1:0] indent_i,
  input  logic [TAB_BITS-1:0]    tab_i,
  input  logic [7:0]             byte_i,
  input  logic                   eoi_i,
  output mode_e                  mode_o,
  output logic [INDENT_BITS-1:0] indent_o,
  output ev_list_t               ev_o,
  output logic [1:0]             cnt_o
);

  logic [INDENT_BITS:0] ind_sum;
  logic [INDENT_BITS:0] ind_add;

  always_comb begin
    ind_add = '0;
    if (byte_i == CH_SPACE) begin
      ind_add = (INDENT_BITS+1)'(1);
    end else if (byte_i == CH_TAB) begin
      ind_add = (INDENT_BITS+1)'(tab_i);
    end
    ind_sum = {1'b0, indent_i} + ind_add;
  end

  always_comb begin
    logic       disp;
    logic [1:0] n;
    disp     = 1'b0;
    n        = '0;
    ev_o     = '0;
    mode_o   = mode_i;
    indent_o = indent_i;
    if (eoi_i) begin
      if (mode_i == MODE_WORD || mode_i == MODE_COMMA) begin
        ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
        n = n + 2'd1;
      end else if (mode_i == MODE_STR || mode_i == MODE_STR_ESC) begin
        ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b1};
        n = n + 2'd1;
      end
      mode_o   = MODE_LINE;
      indent_o = '0;
    end else begin
      unique case (mode_i)
        MODE_LINE: begin
          if (byte_i == CH_NL) begin
            indent_o = '0;
          end else if (byte_i == CH_HASH) begin
            mode_o = MODE_COMMENT;
          end else if (is_space_f(byte_i)) begin
            indent_o = ind_sum[INDENT_BITS] ? INDENT_MAX : ind_sum[INDENT_BITS-1:0];
          end else begin
            ev_o[n] = '{kind: EV_INDENT, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            disp = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (byte_i == CH_NL) begin
            mode_o   = MODE_LINE;
            indent_o = '0;
          end
        end
        MODE_GAP: disp = 1'b1;
        MODE_WORD: begin
          if (is_word_f(byte_i)) begin
            ev_o[n] = '{kind: EV_BYTE, tok_byte: byte_i, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
          end else begin
            ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            disp = 1'b1;
          end
        end
        MODE_STR: begin
          ev_o[n] = '{kind: EV_BYTE, tok_byte: byte_i, first: 1'b0, unterm: 1'b0};
          n = n + 2'd1;
          if (byte_i == CH_BSLASH) begin
            mode_o = MODE_STR_ESC;
          end else if (byte_i == CH_DQUOTE) begin
            ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            mode_o = MODE_GAP;
          end
        end
        MODE_STR_ESC: begin
          ev_o[n] = '{kind: EV_BYTE, tok_byte: byte_i, first: 1'b0, unterm: 1'b0};
          n = n + 2'd1;
          mode_o = MODE_STR;
        end
        MODE_COMMA: begin
          if (byte_i == CH_AT) begin
            ev_o[n] = '{kind: EV_BYTE, tok_byte: byte_i, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            mode_o = MODE_GAP;
          end else begin
            ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            disp = 1'b1;
          end
        end
        default: begin
          mode_o   = MODE_LINE;
          indent_o = '0;
        end
      endcase

      if (disp) begin
        if (byte_i == CH_HASH) begin
          mode_o = MODE_COMMENT;
        end else if (byte_i == CH_NL) begin
          mode_o   = MODE_LINE;
          indent_o = '0;
        end else if (is_space_f(byte_i)) begin
          mode_o = MODE_GAP;
        end else begin
          ev_o[n] = '{kind: EV_BYTE, tok_byte: byte_i, first: 1'b1, unterm: 1'b0};
          n = n + 2'd1;
          if (byte_i == CH_DQUOTE) begin
            mode_o = MODE_STR;
          end else if (is_single_f(byte_i)) begin
            ev_o[n] = '{kind: EV_END, tok_byte: 8'h00, first: 1'b0, unterm: 1'b0};
            n = n + 2'd1;
            mode_o = MODE_GAP;
          end else if (byte_i == CH_COMMA) begin
            mode_o = MODE_COMMA;
          end else begin
            mode_o = MODE_WORD;
          end
        end
      end
    end
    cnt_o = n;
  end

endmodule
`default_nettype wire

/* src/ialt_evbuf.sv */
// Result register: holds the events of one byte and sends them one by one.
`default_nettype none
module ialt_evbuf
  import ialt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ev_list_t               ev_i,
  input  logic [1:0]             cnt_i,
  input  logic [INDENT_BITS-1:0] indent_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [31:0]            m_axis_tdata_o,
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  ev_t                    ev_q [NUM_EV];
  logic [1:0]             cnt_q;
  logic [1:0]             idx_q;
  logic                   valid_q;
  logic [INDENT_BITS-1:0] ind_q;
  logic                   at_last;
  ev_t                    cur;

  assign at_last = idx_q == cnt_q - 2'd1;
  assign free_o  = !valid_q || (m_axis_tready_i && at_last);
  assign cur     = ev_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else if (load_i && free_o && cnt_i != 2'd0) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
      cnt_q   <= cnt_i;
    end else if (valid_q && m_axis_tready_i) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o && cnt_i != 2'd0) begin
      for (int i = 0; i < NUM_EV; i++) begin
        ev_q[i] <= ev_i[i];
      end
      ind_q <= indent_i;
    end
  end

  // tdata: token_byte[7:0], first_of_token[8], indent_level[24:9], unterminated[25]
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {6'b0, cur.unterm, 16'(ind_q), cur.first, cur.tok_byte};
  assign m_axis_tuser_o  = cur.kind;
  assign m_axis_tlast_o  = at_last;

endmodule
`default_nettype wire

/* src/indent_aware_lisp_tokenizer.sv */
// Top level: input register, scan state and result register of the tokenizer.
// Usage:
//   Slave channel s_axis carries one source byte per transaction in tdata[7:0];
//   tlast high marks the end of text (the byte is then ignored) and closes any
//   open token. Master channel m_axis carries token events: tuser is the event
//   kind (line indent, token byte, token end), tdata the byte, first mark,
//   indent and unterminated flag; tlast marks the final event of one byte.
//   cfg_we_i writes tab_indent from cfg_wdata_i; write only while idle.
// Timing:
//   A byte is held in the input register; its events are decoded
//   combinationally into the result register. A byte yielding up to one
//   event sustains one byte per cycle while m_axis_tready_i is high; a byte
//   yielding k events holds the result register until all k are sent.
//   Bytes with no events (whitespace, comments) never load the result register.
// Reset: scan state returns to line start, indent to zero, tab_indent to 2;
//   both registers empty.
// Stall: when m_axis_tready_i is low the result register holds, the input
//   register fills, and s_axis_tready_o drops until the event drains.
`default_nettype none
module indent_aware_lisp_tokenizer
  import ialt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // token_byte[7:0], first_of_token[8],
                                        // indent_level[24:9], unterminated[25]
  output logic [1:0]  m_axis_tuser_o,   // event_kind[1:0]
  output logic        m_axis_tlast_o
);

  logic [TAB_BITS-1:0]    tab_q;
  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   in_eoi_q;
  mode_e                  mode_q, mode_d;
  logic [INDENT_BITS-1:0] indent_q, indent_d;
  ev_list_t               ev;
  logic [1:0]             ev_cnt;
  logic                   buf_free;
  logic                   consume;

  assign consume         = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= TAB_RESET;
    end else if (cfg_we_i) begin
      tab_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_LINE;
      indent_q   <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        mode_q   <= mode_d;
        indent_q <= indent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
  end

  ialt_step u_step (
    .mode_i   (mode_q),
    .indent_i (indent_q),
    .tab_i    (tab_q),
    .byte_i   (in_byte_q),
    .eoi_i    (in_eoi_q),
    .mode_o   (mode_d),
    .indent_o (indent_d),
    .ev_o     (ev),
    .cnt_o    (ev_cnt)
  );

  ialt_evbuf u_evbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_valid_q),
    .ev_i            (ev),
    .cnt_i           (ev_cnt),
    .indent_i        (indent_q),
    .free_o          (buf_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

/* sim/indent_aware_lisp_tokenizer_test.sv */
// Testbench: drives source bytes into the tokenizer and checks every token event it emits.
module indent_aware_lisp_tokenizer_test;
  import ialt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    ev_kind_e               kind;
    logic [7:0]             tok;
    logic                   first;
    logic [INDENT_BITS-1:0] indent;
    logic                   unterm;
    logic                   last;
  } tok_event_t;

  class token_event_board;
    mode_e                  mode;
    logic [INDENT_BITS-1:0] line_indent;
    logic [TAB_BITS-1:0]    tab_indent;
    tok_event_t             expected_events[$];
    tok_event_t             step_events[$];
    int                     errors;
    int                     matched;

    function new();
      mode        = MODE_LINE;
      line_indent = '0;
      tab_indent  = TAB_RESET;
      errors      = 0;
      matched     = 0;
    endfunction

    function bit blank(logic [7:0] c);
      case (c)
        CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit solo(logic [7:0] c);
      case (c)
        CH_LPAR, CH_RPAR, CH_APOS, CH_BTICK, CH_AT: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit plain(logic [7:0] c);
      return !blank(c) && !solo(c) && !(c inside {CH_HASH, CH_DQUOTE, CH_COMMA});
    endfunction

    function void emit(ev_kind_e kind, logic [7:0] b, logic first, logic unterm);
      tok_event_t ev;
      ev.kind   = kind;
      ev.tok    = b;
      ev.first  = first;
      ev.indent = line_indent;
      ev.unterm = unterm;
      ev.last   = 1'b0;
      step_events = {step_events, ev};
    endfunction

    function void start_token(logic [7:0] c);
      if (c == CH_HASH) begin
        mode = MODE_COMMENT;
      end else if (c == CH_NL) begin
        mode        = MODE_LINE;
        line_indent = '0;
      end else if (blank(c)) begin
        mode = MODE_GAP;
      end else begin
        emit(EV_BYTE, c, 1'b1, 1'b0);
        if (c == CH_DQUOTE) begin
          mode = MODE_STR;
        end else if (solo(c)) begin
          emit(EV_END, 8'h00, 1'b0, 1'b0);
          mode = MODE_GAP;
        end else if (c == CH_COMMA) begin
          mode = MODE_COMMA;
        end else begin
          mode = MODE_WORD;
        end
      end
    endfunction

    function void note_byte(logic [7:0] c, logic eoi);
      logic [INDENT_BITS:0] sum;
      step_events.delete();
      if (eoi) begin
        if (mode == MODE_WORD || mode == MODE_COMMA) begin
          emit(EV_END, 8'h00, 1'b0, 1'b0);
        end else if (mode == MODE_STR || mode == MODE_STR_ESC) begin
          emit(EV_END, 8'h00, 1'b0, 1'b1);
        end
        mode        = MODE_LINE;
        line_indent = '0;
      end else begin
        case (mode)
          MODE_LINE: begin
            if (c == CH_NL) begin
              line_indent = '0;
            end else if (c == CH_HASH) begin
              mode = MODE_COMMENT;
            end else if (blank(c)) begin
              sum = {1'b0, line_indent};
              if (c == CH_SPACE) sum = sum + (INDENT_BITS+1)'(1);
              else if (c == CH_TAB) sum = sum + (INDENT_BITS+1)'(tab_indent);
              line_indent = sum[INDENT_BITS] ? INDENT_MAX : sum[INDENT_BITS-1:0];
            end else begin
              emit(EV_INDENT, 8'h00, 1'b0, 1'b0);
              start_token(c);
            end
          end
          MODE_COMMENT: begin
            if (c == CH_NL) begin
              mode        = MODE_LINE;
              line_indent = '0;
            end
          end
          MODE_GAP: start_token(c);
          MODE_WORD: begin
            if (plain(c)) begin
              emit(EV_BYTE, c, 1'b0, 1'b0);
            end else begin
              emit(EV_END, 8'h00, 1'b0, 1'b0);
              start_token(c);
            end
          end
          MODE_STR: begin
            emit(EV_BYTE, c, 1'b0, 1'b0);
            if (c == CH_BSLASH) begin
              mode = MODE_STR_ESC;
            end else if (c == CH_DQUOTE) begin
              emit(EV_END, 8'h00, 1'b0, 1'b0);
              mode = MODE_GAP;
            end
          end
          MODE_STR_ESC: begin
            emit(EV_BYTE, c, 1'b0, 1'b0);
            mode = MODE_STR;
          end
          MODE_COMMA: begin
            if (c == CH_AT) begin
              emit(EV_BYTE, c, 1'b0, 1'b0);
              emit(EV_END, 8'h00, 1'b0, 1'b0);
              mode = MODE_GAP;
            end else begin
              emit(EV_END, 8'h00, 1'b0, 1'b0);
              start_token(c);
            end
          end
          default: begin
            mode        = MODE_LINE;
            line_indent = '0;
          end
        endcase
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      expected_events = {expected_events, step_events};
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch at event %0d: %s", matched, what);
    endtask

    task check_event(logic [1:0] user, logic [31:0] data, logic lst);
      tok_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("event with none pending: kind %0d data %h", user, data));
        return;
      end
      want = expected_events.pop_front();
      matched++;
      if (user !== want.kind)
        report($sformatf("event_kind %0d, want %0d", user, want.kind));
      if (data[7:0] !== want.tok)
        report($sformatf("token_byte %h, want %h", data[7:0], want.tok));
      if (data[8] !== want.first)
        report($sformatf("first_of_token %b, want %b", data[8], want.first));
      if (data[24:9] !== want.indent)
        report($sformatf("indent_level %0d, want %0d", data[24:9], want.indent));
      if (data[25] !== want.unterm)
        report($sformatf("unterminated %b, want %b", data[25], want.unterm));
      if (lst !== want.last)
        report($sformatf("last %b, want %b", lst, want.last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  token_event_board board = new();
  logic calm;
  int   cycle_count;
  int   items_sent;
  int   ends_sent;
  int   tab_settings;

  indent_aware_lisp_tokenizer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL indent_aware_lisp_tokenizer");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_event(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
  end

  initial begin
    int stall;
    int quiet;
    m_axis_tready_i = 1'b0;
    stall = 0;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && quiet == 0 && !calm) begin
        if ($urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
        else if ($urandom_range(0, 40) == 0) quiet = $urandom_range(20, 60);
      end
      if (quiet > 0) quiet--;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b, eoi);
    items_sent++;
    if (eoi) ends_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_random();
    int         r;
    logic [7:0] b;
    logic       e;
    r = $urandom_range(0, 99);
    e = 1'b0;
    if (r < 28) b = 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 36) b = CH_SPACE;
    else if (r < 40) b = CH_TAB;
    else if (r < 46) b = CH_NL;
    else if (r < 52) b = $urandom_range(0, 1) ? CH_LPAR : CH_RPAR;
    else if (r < 55) begin
      case ($urandom_range(0, 2))
        0: b = CH_APOS;
        1: b = CH_BTICK;
        default: b = CH_AT;
      endcase
    end
    else if (r < 59) b = CH_COMMA;
    else if (r < 65) b = CH_DQUOTE;
    else if (r < 68) b = CH_BSLASH;
    else if (r < 70) b = CH_HASH;
    else if (r < 72) b = CH_VT + 8'($urandom_range(0, 2));
    else if (r < 86) b = 8'($urandom_range(0, 255));
    else if (r < 88) begin
      b = 8'($urandom_range(0, 255));
      e = 1'b1;
    end
    else b = 8'h30 + 8'($urandom_range(0, 9));
    send_item(b, e);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.expected_events.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_tab(input logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 4'($urandom_range(0, 15));
    board.tab_indent = v;
    tab_settings++;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 4'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'd0;
    s_axis_tlast_i  = 1'b0;
    calm            = 1'b0;
    cycle_count     = 0;
    items_sent      = 0;
    ends_sent       = 0;
    tab_settings    = 1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text(" \t(a,@");
    send_text(",x");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("\"\\");
    send_item(8'h5A, 1'b1);
    send_text(" \n#c\n\t\"a\nb\"");
    send_item(CH_VT, 1'b0);
    send_text("`'");
    send_item(CH_CR, 1'b0);
    send_text(",");
    send_item(8'hA5, 1'b1);

    // build a deep indent with a run of wide tabs
    drain();
    write_tab(4'd15);
    repeat (40) send_item(CH_TAB, 1'b0);
    send_text("z\"q");
    send_item(8'h00, 1'b1);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: write_tab(4'd0);
        1: write_tab(4'd15);
        default: write_tab(4'($urandom_range(1, 14)));
      endcase
      if (p == 3) calm = 1'b1;
      repeat (100) send_random();
    end

    drain();
    $display("Sent %0d source bytes with %0d end marks under %0d tab settings,",
             items_sent, ends_sent, tab_settings);
    $display("including a deep tab indent; checked %0d token events, %0d mismatches.",
             board.matched, board.errors);
    if (board.errors == 0) begin
      $display("PASS indent_aware_lisp_tokenizer");
    end else begin
      $display("FAIL indent_aware_lisp_tokenizer");
    end
    $finish;
  end

endmodule

/* indent_aware_lisp_tokenizer.f */
src/ialt_pkg.sv
src/ialt_step.sv
src/ialt_evbuf.sv
src/indent_aware_lisp_tokenizer.sv
sim/indent_aware_lisp_tokenizer_test.sv
